FILE: sv/lvr_pkg.sv
package lvr_pkg;

  localparam int CoordW    = 32;
  localparam int AngW      = 16;
  localparam int CfgW      = 16;
  localparam int DiffW     = 34;
  localparam int CordW     = 34;
  localparam int CordSteps = 30;
  localparam int CordicLat = CordSteps + 1;
  localparam int SqrtLat   = 32;
  localparam int HW        = 40;
  localparam int NumW      = 80;
  localparam int QuoW      = 44;
  localparam int DivLat    = QuoW;

  localparam logic signed [CordW-1:0] Q30Pi     = 34'sd3373259426;
  localparam logic signed [CordW-1:0] Q30HalfPi = 34'sd1686629713;
  localparam logic signed [CordW-1:0] CordGain  = 34'sd652032874;
  localparam logic [QuoW-1:0]         QuoCap    = 44'h100_0000_0000;

  localparam logic [31:0] AtanQ30 [CordSteps] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  typedef enum logic {
    REG_ENABLE = 1'b0,
    REG_MIN_H  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     chg;
  } res_t;

endpackage

FILE: sv/lvr_delay.sv
module lvr_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign q_o = pipe_q[N-1];

endmodule

FILE: sv/lvr_cordic.sv
module lvr_cordic import lvr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AngW-1:0]  ang_i,
  output logic signed [CordW-1:0] cos_o,
  output logic signed [CordW-1:0] sin_o
);

  logic signed [CordW-1:0] x_q    [CordSteps];
  logic signed [CordW-1:0] y_q    [CordSteps];
  logic signed [CordW-1:0] z_q    [CordSteps];
  logic                    flip_q [CordSteps];
  logic signed [CordW-1:0] z0, zr;
  logic                    fr;

  // Fold the angle into [-pi/2, pi/2]; the half turn negates both outputs.
  always_comb begin
    z0 = CordW'(ang_i) <<< 17;
    zr = z0;
    fr = 1'b0;
    if (z0 > Q30HalfPi) begin
      zr = z0 - Q30Pi;
      fr = 1'b1;
    end else if (z0 < -Q30HalfPi) begin
      zr = z0 + Q30Pi;
      fr = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]    <= zr;
      flip_q[0] <= fr;
    end
  end

  for (genvar i = 0; i < CordSteps; i++) begin : g_step
    logic signed [CordW-1:0] xin, yin, xs, ys, xn, yn, zn, at;

    if (i == 0) begin : g_first
      assign xin = CordGain;
      assign yin = '0;
    end else begin : g_rest
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
    end

    always_comb begin
      at = CordW'(AtanQ30[i]);
      xs = xin >>> i;
      ys = yin >>> i;
      if (!z_q[i][CordW-1]) begin
        xn = xin - ys;
        yn = yin + xs;
        zn = z_q[i] - at;
      end else begin
        xn = xin + ys;
        yn = yin - xs;
        zn = z_q[i] + at;
      end
      if (i == CordSteps - 1 && flip_q[i]) begin
        xn = -xn;
        yn = -yn;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= xn;
        y_q[i] <= yn;
      end
    end

    if (i < CordSteps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i+1]    <= zn;
          flip_q[i+1] <= flip_q[i];
        end
      end
    end
  end

  assign cos_o = x_q[CordSteps-1];
  assign sin_o = y_q[CordSteps-1];

endmodule

FILE: sv/lvr_isqrt.sv
module lvr_isqrt import lvr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [2*SqrtLat-1:0]   rad_i,
  output logic [SqrtLat-1:0]     root_o
);

  localparam int W = 2 * SqrtLat;

  logic [W-1:0] n_q [SqrtLat];
  logic [W-1:0] r_q [SqrtLat];

  // One result bit per stage, from the top bit pair down.
  for (genvar k = 0; k < SqrtLat; k++) begin : g_bit
    localparam logic [W-1:0] Bit = W'(1) << (2 * (SqrtLat - 1 - k));
    logic [W-1:0] nin, rin, tr;

    if (k == 0) begin : g_first
      assign nin = rad_i;
      assign rin = '0;
    end else begin : g_rest
      assign nin = n_q[k-1];
      assign rin = r_q[k-1];
    end

    assign tr = rin + Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (nin >= tr) begin
          n_q[k] <= nin - tr;
          r_q[k] <= (rin >> 1) + Bit;
        end else begin
          n_q[k] <= nin;
          r_q[k] <= rin >> 1;
        end
      end
    end
  end

  assign root_o = r_q[SqrtLat-1][SqrtLat-1:0];

endmodule

FILE: sv/lvr_div.sv
module lvr_div import lvr_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [HW-1:0]   den_i,
  output logic [QuoW-1:0] quo_o
);

  logic [HW-1:0]   rem_q [QuoW];
  logic [QuoW-1:0] low_q [QuoW];
  logic [HW-1:0]   den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];

  // Restoring division, one quotient bit per stage. The upper part of the
  // dividend is already below the divisor, so the quotient fits in QuoW bits.
  for (genvar j = 0; j < QuoW; j++) begin : g_bit
    localparam int B = QuoW - 1 - j;
    logic [HW-1:0]   rem_in, den_in;
    logic [QuoW-1:0] low_in, quo_in;
    logic [HW:0]     trial;
    logic            ge;

    if (j == 0) begin : g_first
      assign rem_in = HW'(num_i[NumW-1:QuoW]);
      assign low_in = num_i[QuoW-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[j-1];
      assign low_in = low_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign trial = {rem_in, low_in[B]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? HW'(trial - {1'b0, den_in}) : HW'(trial);
        low_q[j] <= low_in;
        den_q[j] <= den_in;
        quo_q[j] <= quo_in | (QuoW'(ge) << B);
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

FILE: sv/look_vector_yaw_pitch_rotate.sv
// Throughput: one transaction per cycle while in_stall_o is low; the depth is set by the
// 30-step yaw CORDIC, the 32-stage square root and the 44-stage quotient pipeline in
// series, while the pitch CORDIC runs alongside the square root.
// Reset: asynchronous, active low; clears all valid bits, enable to 1, min_horizontal to 7.
module look_vector_yaw_pitch_rotate import lvr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] eye_x_i,
  input  logic signed [CoordW-1:0] eye_y_i,
  input  logic signed [CoordW-1:0] eye_z_i,
  input  logic signed [CoordW-1:0] target_x_i,
  input  logic signed [CoordW-1:0] target_y_i,
  input  logic signed [CoordW-1:0] target_z_i,
  input  logic signed [AngW-1:0]   yaw_angle_i,
  input  logic signed [AngW-1:0]   pitch_angle_i,
  input  logic                     pose_valid_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CoordW-1:0] new_target_x_o,
  output logic signed [CoordW-1:0] new_target_y_o,
  output logic signed [CoordW-1:0] new_target_z_o,
  output logic                     was_changed_o
);

  localparam int ICs     = CordicLat;
  localparam int IH0     = ICs + 5 + SqrtLat;
  localparam int IH      = IH0 + 1;
  localparam int INum    = IH + 4;
  localparam int IQ      = INum + DivLat;
  localparam int PDly    = IH - CordicLat;
  localparam int RxDly   = IH - (ICs + 2);
  localparam int SDly    = IH0 - (ICs + 3);
  localparam int TailDly = DivLat + 1;
  localparam int RxW     = 36;
  localparam int NhW     = 44;
  localparam int ShW     = 4;
  localparam int AxW     = 31;
  localparam int HLoW    = 20;
  localparam int NLoW    = 22;
  localparam int RndW    = 80;
  localparam int SumW    = 46;
  localparam int EtW     = 6 * CoordW + 1;
  localparam int TailW   = 2 * RxW + NhW + 3;

  function automatic logic signed [RndW-1:0] rnd_q30(input logic signed [RndW-1:0] p);
    rnd_q30 = (p + 80'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [SumW-1:0] v);
    if (v > 46'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -46'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[CoordW-1:0];
    end
  endfunction

  // ---------------------------------------------------------------- control
  logic            adv, skid_vld_q, out_vld_q;
  logic [IQ:0]     vld_q;
  logic            enable_q;
  logic [CfgW-1:0] min_h_q;

  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      min_h_q  <= CfgW'(7);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ENABLE: enable_q <= cfg_wdata_i[0];
        REG_MIN_H:  min_h_q  <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[IQ-1:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- input stage
  logic signed [CoordW-1:0] ex0_q, ey0_q, ez0_q, tx0_q, ty0_q, tz0_q;
  logic signed [DiffW-1:0]  dx0_q, dy0_q, dz0_q;
  logic signed [AngW-1:0]   yaw0_q, pitch0_q;
  logic                     pass0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ex0_q    <= eye_x_i;
      ey0_q    <= eye_y_i;
      ez0_q    <= eye_z_i;
      tx0_q    <= target_x_i;
      ty0_q    <= target_y_i;
      tz0_q    <= target_z_i;
      dx0_q    <= DiffW'(target_x_i) - DiffW'(eye_x_i);
      dy0_q    <= DiffW'(target_y_i) - DiffW'(eye_y_i);
      dz0_q    <= DiffW'(target_z_i) - DiffW'(eye_z_i);
      yaw0_q   <= yaw_angle_i;
      pitch0_q <= pitch_angle_i;
      pass0_q  <= !enable_q || !pose_valid_i ||
                  (yaw_angle_i == '0 && pitch_angle_i == '0);
    end
  end

  // ---------------------------------------------------------------- side delays
  logic [2*DiffW-1:0]      dxz_cs;
  logic signed [DiffW-1:0] dx_cs, dz_cs, dy_h;
  logic [DiffW-1:0]        dy_h_raw;
  logic [EtW-1:0]          et_q;
  logic [AngW-1:0]         pitch_dly;
  logic signed [CordW-1:0] cy, sy, cp, sp;

  lvr_delay #(.W(2*DiffW), .N(ICs)) u_dly_xz (
    .clk_i, .en_i(adv), .d_i({dx0_q, dz0_q}), .q_o(dxz_cs)
  );
  lvr_delay #(.W(DiffW), .N(IH)) u_dly_y (
    .clk_i, .en_i(adv), .d_i(dy0_q), .q_o(dy_h_raw)
  );
  lvr_delay #(.W(EtW), .N(IQ)) u_dly_et (
    .clk_i, .en_i(adv),
    .d_i({ex0_q, ey0_q, ez0_q, tx0_q, ty0_q, tz0_q, pass0_q}), .q_o(et_q)
  );
  lvr_delay #(.W(AngW), .N(PDly)) u_dly_pitch (
    .clk_i, .en_i(adv), .d_i(pitch0_q), .q_o(pitch_dly)
  );

  assign dx_cs = $signed(dxz_cs[2*DiffW-1:DiffW]);
  assign dz_cs = $signed(dxz_cs[DiffW-1:0]);
  assign dy_h  = $signed(dy_h_raw);

  lvr_cordic u_cordic_yaw (
    .clk_i, .en_i(adv), .ang_i(yaw0_q), .cos_o(cy), .sin_o(sy)
  );
  lvr_cordic u_cordic_pitch (
    .clk_i, .en_i(adv), .ang_i($signed(pitch_dly)), .cos_o(cp), .sin_o(sp)
  );

  // ---------------------------------------------------------------- yaw rotation
  logic signed [2*CordW-1:0] pxc1_q, pzs1_q, pxs1_q, pzc1_q;
  logic signed [RxW-1:0]     rx2_q, rz2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxc1_q <= dx_cs * cy;
      pzs1_q <= dz_cs * sy;
      pxs1_q <= dx_cs * sy;
      pzc1_q <= dz_cs * cy;
      rx2_q  <= RxW'(rnd_q30(pxc1_q) - rnd_q30(pzs1_q));
      rz2_q  <= RxW'(rnd_q30(pxs1_q) + rnd_q30(pzc1_q));
    end
  end

  // ---------------------------------------------------------------- horizontal length
  logic [RxW-1:0]   axa, aza, axz;
  logic [ShW-1:0]   sh;
  logic [AxW-1:0]   ax3_q, az3_q;
  logic [ShW-1:0]   s3_q, s_h0;
  logic [2*AxW-1:0] sqx4_q, sqz4_q;
  logic [2*SqrtLat-1:0] rad5_q;
  logic [SqrtLat-1:0]   h0;

  // Pre-shift so both magnitudes stay below 2^31 before squaring.
  always_comb begin
    axa = rx2_q[RxW-1] ? RxW'(-rx2_q) : RxW'(rx2_q);
    aza = rz2_q[RxW-1] ? RxW'(-rz2_q) : RxW'(rz2_q);
    axz = axa | aza;
    sh  = ShW'(8);
    for (int k = 8; k >= 0; k--) begin
      if ((axz >> k) < (RxW'(1) << 31)) begin
        sh = ShW'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax3_q  <= AxW'(axa >> sh);
      az3_q  <= AxW'(aza >> sh);
      s3_q   <= sh;
      sqx4_q <= ax3_q * ax3_q;
      sqz4_q <= az3_q * az3_q;
      rad5_q <= (2*SqrtLat)'(sqx4_q) + (2*SqrtLat)'(sqz4_q);
    end
  end

  lvr_isqrt u_isqrt (.clk_i, .en_i(adv), .rad_i(rad5_q), .root_o(h0));

  lvr_delay #(.W(ShW), .N(SDly)) u_dly_s (
    .clk_i, .en_i(adv), .d_i(s3_q), .q_o(s_h0)
  );

  logic [2*RxW-1:0]      rxz_h;
  lvr_delay #(.W(2*RxW), .N(RxDly)) u_dly_rxz (
    .clk_i, .en_i(adv), .d_i({rx2_q, rz2_q}), .q_o(rxz_h)
  );

  // ---------------------------------------------------------------- pitch tilt
  logic [HW-1:0]                  h6_q, h7_q, h8_q, h9_q, h10_q;
  logic                           tilt6_q, tilt7_q, tilt8_q, tilt9_q;
  logic signed [HLoW+CordW:0]     pchl7_q, pchh7_q, pshl7_q, pshh7_q;
  logic signed [2*CordW-1:0]      pdys7_q, pdyc7_q;
  logic signed [RxW-1:0]          rx7_q, rz7_q, rx8_q, rz8_q, rx9_q, rz9_q;
  logic signed [DiffW-1:0]        dy7_q;
  logic signed [NhW-1:0]          nh8_q, yv8_q, yv9_q;
  logic signed [RndW-1:0]         hc, hs;
  logic [NhW-1:0]                 nhm;
  logic [RxW-1:0]                 rxm, rzm;
  logic [RxW+NLoW-1:0]            pxl9_q, pxh9_q, pzl9_q, pzh9_q;
  logic                           negx9_q, negz9_q;
  logic [NumW-1:0]                numx10_q, numz10_q;

  always_comb begin
    hc  = (RndW'(pchh7_q) <<< HLoW) + RndW'(pchl7_q);
    hs  = (RndW'(pshh7_q) <<< HLoW) + RndW'(pshl7_q);
    nhm = nh8_q[NhW-1] ? NhW'(-nh8_q) : NhW'(nh8_q);
    rxm = rx8_q[RxW-1] ? RxW'(-rx8_q) : RxW'(rx8_q);
    rzm = rz8_q[RxW-1] ? RxW'(-rz8_q) : RxW'(rz8_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h6_q     <= HW'(h0) << s_h0;
      tilt6_q  <= (HW'(h0) << s_h0) > HW'(min_h_q);

      pchl7_q  <= $signed({1'b0, h6_q[HLoW-1:0]}) * cp;
      pchh7_q  <= $signed({1'b0, h6_q[HW-1:HLoW]}) * cp;
      pshl7_q  <= $signed({1'b0, h6_q[HLoW-1:0]}) * sp;
      pshh7_q  <= $signed({1'b0, h6_q[HW-1:HLoW]}) * sp;
      pdys7_q  <= dy_h * sp;
      pdyc7_q  <= dy_h * cp;
      h7_q     <= h6_q;
      tilt7_q  <= tilt6_q;
      rx7_q    <= $signed(rxz_h[2*RxW-1:RxW]);
      rz7_q    <= $signed(rxz_h[RxW-1:0]);
      dy7_q    <= dy_h;

      nh8_q    <= NhW'(rnd_q30(hc) - rnd_q30(pdys7_q));
      yv8_q    <= tilt7_q ? NhW'(rnd_q30(hs) + rnd_q30(pdyc7_q)) : NhW'(dy7_q);
      h8_q     <= h7_q;
      tilt8_q  <= tilt7_q;
      rx8_q    <= rx7_q;
      rz8_q    <= rz7_q;

      pxl9_q   <= rxm * nhm[NLoW-1:0];
      pxh9_q   <= rxm * nhm[NhW-1:NLoW];
      pzl9_q   <= rzm * nhm[NLoW-1:0];
      pzh9_q   <= rzm * nhm[NhW-1:NLoW];
      negx9_q  <= rx8_q[RxW-1] ^ nh8_q[NhW-1];
      negz9_q  <= rz8_q[RxW-1] ^ nh8_q[NhW-1];
      h9_q     <= h8_q;
      tilt9_q  <= tilt8_q;
      yv9_q    <= yv8_q;
      rx9_q    <= rx8_q;
      rz9_q    <= rz8_q;

      // Half the divisor is added so the quotient rounds half up.
      numx10_q <= (NumW'(pxh9_q) << NLoW) + NumW'(pxl9_q) + NumW'(h9_q >> 1);
      numz10_q <= (NumW'(pzh9_q) << NLoW) + NumW'(pzl9_q) + NumW'(h9_q >> 1);
      h10_q    <= h9_q;
    end
  end

  logic [QuoW-1:0]  quo_x, quo_z;
  logic [TailW-1:0] tail_q;

  lvr_div u_div_x (.clk_i, .en_i(adv), .num_i(numx10_q), .den_i(h10_q), .quo_o(quo_x));
  lvr_div u_div_z (.clk_i, .en_i(adv), .num_i(numz10_q), .den_i(h10_q), .quo_o(quo_z));

  lvr_delay #(.W(TailW), .N(TailDly)) u_dly_tail (
    .clk_i, .en_i(adv),
    .d_i({rx9_q, rz9_q, yv9_q, tilt9_q, negx9_q, negz9_q}), .q_o(tail_q)
  );

  // ---------------------------------------------------------------- result
  logic signed [RxW-1:0]    rx_t, rz_t;
  logic signed [NhW-1:0]    yv_t;
  logic                     tilt_t, negx_t, negz_t, pass_t;
  logic signed [CoordW-1:0] ex_t, ey_t, ez_t, tx_t, ty_t, tz_t;
  logic [QuoW-1:0]          qx, qz;
  logic signed [SumW-1:0]   vx, vz;
  res_t                     res, out_q, skid_q;

  always_comb begin
    {rx_t, rz_t, yv_t, tilt_t, negx_t, negz_t} = tail_q;
    {ex_t, ey_t, ez_t, tx_t, ty_t, tz_t, pass_t} = et_q;
    qx = (quo_x > QuoCap) ? QuoCap : quo_x;
    qz = (quo_z > QuoCap) ? QuoCap : quo_z;
    if (tilt_t) begin
      vx = negx_t ? -SumW'(qx) : SumW'(qx);
      vz = negz_t ? -SumW'(qz) : SumW'(qz);
    end else begin
      vx = SumW'(rx_t);
      vz = SumW'(rz_t);
    end
    if (pass_t) begin
      res.x   = tx_t;
      res.y   = ty_t;
      res.z   = tz_t;
      res.chg = 1'b0;
    end else begin
      res.x   = sat32(SumW'(ex_t) + vx);
      res.y   = sat32(SumW'(ey_t) + SumW'(yv_t));
      res.z   = sat32(SumW'(ez_t) + vz);
      res.chg = 1'b1;
    end
  end

  // Output register plus one skid entry; the pipeline freezes only while the
  // skid entry is occupied.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (adv) begin
      if (!out_vld_q || !out_stall_i) begin
        out_vld_q <= vld_q[IQ];
      end else if (vld_q[IQ]) begin
        skid_vld_q <= 1'b1;
      end
    end else if (!out_stall_i) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!out_vld_q || !out_stall_i) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (!out_stall_i) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign new_target_x_o = out_q.x;
  assign new_target_y_o = out_q.y;
  assign new_target_z_o = out_q.z;
  assign was_changed_o  = out_q.chg;

  // ---------------------------------------------------------------- checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without a valid output");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i && vld_q[IQ]))
    else $error("skid entry filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !out_stall_i |=> !skid_vld_q && out_vld_q)
    else $error("skid entry not moved to the output");

endmodule

FILE: bench/tb_look_vector_yaw_pitch_rotate.sv
`timescale 1ns / 1ps

module tb_look_vector_yaw_pitch_rotate;
  import lvr_pkg::*;

  localparam int DrainCycles = 140;
  localparam int CycleLimit  = 1000000;

  typedef struct packed {
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic signed [CoordW-1:0] ez;
    logic signed [CoordW-1:0] tx;
    logic signed [CoordW-1:0] ty;
    logic signed [CoordW-1:0] tz;
    logic signed [AngW-1:0]   yaw;
    logic signed [AngW-1:0]   pitch;
    logic                     pose;
  } pose_item_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [0:0]               cfg_idx_i = REG_ENABLE;
  logic [CfgW-1:0]          cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [CoordW-1:0] eye_x_i = '0;
  logic signed [CoordW-1:0] eye_y_i = '0;
  logic signed [CoordW-1:0] eye_z_i = '0;
  logic signed [CoordW-1:0] target_x_i = '0;
  logic signed [CoordW-1:0] target_y_i = '0;
  logic signed [CoordW-1:0] target_z_i = '0;
  logic signed [AngW-1:0]   yaw_angle_i = '0;
  logic signed [AngW-1:0]   pitch_angle_i = '0;
  logic                     pose_valid_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [CoordW-1:0] new_target_x_o;
  logic signed [CoordW-1:0] new_target_y_o;
  logic signed [CoordW-1:0] new_target_z_o;
  logic                     was_changed_o;

  look_vector_yaw_pitch_rotate dut (.*);

  always #5 clk_i = ~clk_i;

  // Local copy of the configuration registers.
  logic        rot_enable = 1'b1;
  logic [15:0] rot_min_h  = 16'd7;

  res_t pending_targets[$];
  int   mismatches = 0;
  int   cycles = 0;

  function automatic longint round_q30(longint a, longint c);
    return (a * c + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void cordic_sincos(input longint ang, output longint c, output longint s);
    longint zz, xx, yy, nx;
    bit flip;
    zz = ang;
    xx = CordGain;
    yy = 0;
    flip = 1'b0;
    if (zz > Q30HalfPi) begin
      zz -= Q30Pi;
      flip = 1'b1;
    end else if (zz < -Q30HalfPi) begin
      zz += Q30Pi;
      flip = 1'b1;
    end
    for (int i = 0; i < CordSteps; i++) begin
      if (zz >= 0) begin
        nx = xx - (yy >>> i);
        yy = yy + (xx >>> i);
        zz -= longint'(AtanQ30[i]);
      end else begin
        nx = xx + (yy >>> i);
        yy = yy - (xx >>> i);
        zz += longint'(AtanQ30[i]);
      end
      xx = nx;
    end
    c = flip ? -xx : xx;
    s = flip ? -yy : yy;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Rounds v * num / den on magnitudes, half up, caps at 2^40, then applies the sign.
  function automatic longint rescale(longint v, longint num, longint unsigned den);
    logic [127:0] mag_v, mag_n, q;
    mag_v = (v < 0) ? 128'(-v) : 128'(v);
    mag_n = (num < 0) ? 128'(-num) : 128'(num);
    q = (mag_v * mag_n + 128'(den >> 1)) / 128'(den);
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return ((v < 0) != (num < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic res_t rotate_target(pose_item_t it, logic en, logic [15:0] min_h);
    res_t r;
    longint dx, dy, dz, rx, rz, cy, sy, cp, sp, nh, ny;
    longint unsigned ax, az, h;
    int sh;
    if (!en || !it.pose || (it.yaw == 0 && it.pitch == 0)) begin
      r.x = it.tx;
      r.y = it.ty;
      r.z = it.tz;
      r.chg = 1'b0;
      return r;
    end
    dx = longint'(it.tx) - longint'(it.ex);
    dy = longint'(it.ty) - longint'(it.ey);
    dz = longint'(it.tz) - longint'(it.ez);
    cordic_sincos(longint'(it.yaw) * 131072, cy, sy);
    rx = round_q30(dx, cy) - round_q30(dz, sy);
    rz = round_q30(dx, sy) + round_q30(dz, cy);
    ax = (rx < 0) ? -rx : rx;
    az = (rz < 0) ? -rz : rz;
    sh = 0;
    while (sh < 8 && ((ax >> sh) >= (64'd1 << 31) || (az >> sh) >= (64'd1 << 31))) sh++;
    ax >>= sh;
    az >>= sh;
    h = floor_sqrt(ax * ax + az * az) << sh;
    if (h > min_h) begin
      cordic_sincos(longint'(it.pitch) * 131072, cp, sp);
      nh = round_q30(longint'(h), cp) - round_q30(dy, sp);
      ny = round_q30(longint'(h), sp) + round_q30(dy, cp);
      rx = rescale(rx, nh, h);
      rz = rescale(rz, nh, h);
      dy = ny;
    end
    r.x = clamp32(longint'(it.ex) + rx);
    r.y = clamp32(longint'(it.ey) + dy);
    r.z = clamp32(longint'(it.ez) + rz);
    r.chg = 1'b1;
    return r;
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  always @(negedge clk_i) begin : stall_driver
    int left;
    if (left > 0) begin
      left--;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      left = $urandom_range(30, 1);
    end else if ($urandom_range(3) == 0) begin
      out_stall_i <= 1'b1;
      left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_checker
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_targets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: x=%0d", new_target_x_o);
      end else begin
        want = pending_targets.pop_front();
        if (new_target_x_o !== want.x || new_target_y_o !== want.y ||
            new_target_z_o !== want.z || was_changed_o !== want.chg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected (%0d %0d %0d %b) got (%0d %0d %0d %b)",
                     want.x, want.y, want.z, want.chg, new_target_x_o,
                     new_target_y_o, new_target_z_o, was_changed_o);
        end
      end
    end
  end

  task automatic send_pose(pose_item_t it, bit gaps);
    int n;
    n = gaps ? pick_gap() : 0;
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    eye_x_i       <= it.ex;
    eye_y_i       <= it.ey;
    eye_z_i       <= it.ez;
    target_x_i    <= it.tx;
    target_y_i    <= it.ty;
    target_z_i    <= it.tz;
    yaw_angle_i   <= it.yaw;
    pitch_angle_i <= it.pitch;
    pose_valid_i  <= it.pose;
    do @(posedge clk_i); while (in_stall_o);
    pending_targets.push_back(rotate_target(it, rot_enable, rot_min_h));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_targets.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ENABLE) rot_enable = value[0];
    else rot_min_h = value;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    logic [31:0] picks[5] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1};
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2097152)) - 1048576);
      2: return 32'($signed($urandom_range(40)) - 20);
      default: return picks[$urandom_range(4)];
    endcase
  endfunction

  function automatic pose_item_t random_pose();
    pose_item_t it;
    int mode;
    mode = $urandom_range(9);
    mode = (mode < 3) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
    it.ex = rand_coord(mode);
    it.ey = rand_coord(mode);
    it.ez = rand_coord(mode);
    it.tx = rand_coord(mode);
    it.ty = rand_coord(mode);
    it.tz = rand_coord(mode);
    it.yaw = ($urandom_range(9) == 0) ? '0 : 16'($urandom);
    it.pitch = ($urandom_range(9) == 0) ? '0 : 16'($urandom);
    it.pose = ($urandom_range(9) != 0);
    return it;
  endfunction

  function automatic pose_item_t make_pose(longint ex, longint ey, longint ez, longint tx,
                                           longint ty, longint tz, int yaw, int pitch,
                                           bit pose);
    pose_item_t it;
    it = '{ex[31:0], ey[31:0], ez[31:0], tx[31:0], ty[31:0], tz[31:0],
           yaw[15:0], pitch[15:0], pose};
    return it;
  endfunction

  task automatic test_directed();
    send_pose(make_pose(0, 0, 0, 65536, 0, 0, 2000, 1000, 1), 0);
    send_pose(make_pose(0, 0, 0, 65536, 0, 65536, 0, 0, 1), 0);        // zero offset
    send_pose(make_pose(0, 0, 0, 65536, 0, 65536, 500, 500, 0), 0);    // no pose
    send_pose(make_pose(0, 0, 0, 65536, 3, 65536, 0, -3000, 1), 0);
    send_pose(make_pose(0, 0, 0, 3, 100, 2, 1200, 1200, 1), 0);        // short horizontal
    send_pose(make_pose(0, 0, 0, 7, 100, 0, 0, 1200, 1), 0);
    send_pose(make_pose(5, 5, 5, 5, 5, 5, 300, 300, 1), 0);            // eye on target
    send_pose(make_pose(-2147483648, -2147483648, -2147483648, 2147483647, 2147483647,
                        2147483647, 32767, 32767, 1), 0);
    send_pose(make_pose(2147483647, 2147483647, 2147483647, -2147483648, -2147483648,
                        -2147483648, -32768, -32768, 1), 0);
    send_pose(make_pose(2147483647, 0, 2147483647, 2147483647, 0, 2147483647,
                        12868, 0, 1), 0);
    send_pose(make_pose(0, 0, 0, 1000000, -1000000, -1000000, 32767, -32768, 1), 0);
    send_pose(make_pose(0, 0, 0, -65536, 65536, 0, -12868, 12868, 1), 0);
    send_pose(make_pose(2147483647, 2147483647, 2147483647, -2147483648, 2147483647,
                        -2147483648, 25736, 6434, 1), 0);
    send_pose(make_pose(0, 0, 0, 0, 2147483647, 1, 1, -1, 1), 0);
    wait_idle();
    write_reg(REG_ENABLE, 16'hfffe);                                     // disabled
    send_pose(make_pose(0, 0, 0, 65536, 0, 65536, 4000, 4000, 1), 0);
    send_pose(make_pose(-1, -1, -1, -2147483648, 2147483647, 0, 32767, -32768, 1), 0);
    wait_idle();
    write_reg(REG_ENABLE, 16'h0001);
  endtask

  task automatic test_config_extremes();
    write_reg(REG_MIN_H, 16'hffff);
    for (int i = 0; i < 40; i++) send_pose(random_pose(), 1);
    wait_idle();
    write_reg(REG_MIN_H, 16'h0000);
    for (int i = 0; i < 40; i++) send_pose(random_pose(), 1);
    wait_idle();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_ENABLE, {15'($urandom), (phase != 3)});
      write_reg(REG_MIN_H, (phase == 0) ? 16'd7 : 16'($urandom_range(65535)));
      for (int i = 0; i < 240; i++) begin
        send_pose(random_pose(), 1);
        // Once hold the sender until the pipeline has fully drained.
        if (phase == 2 && i == 120) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          wait (pending_targets.size() == 0);
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_config_extremes();
    test_random();
    if (mismatches == 0 && pending_targets.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
